### rtl/fpta_pkg.sv
// ----------------------------------------------------------------------------
// fpta_pkg
// Shared constants and types for the floor projection texel address block.
// ----------------------------------------------------------------------------
package fpta_pkg;

	localparam int PIX_COLS  = 512;
	localparam int PIX_ROWS  = 256;
	localparam int MAP_W     = 1024;
	localparam int MAP_H     = 1024;
	localparam int FRAC_BITS = 24;
	localparam int REG_W     = 26;
	localparam int NUM_REGS  = 8;
	localparam int HORIZON   = PIX_ROWS / 2;

	localparam int COL_W   = 9;
	localparam int ROW_W   = 8;
	localparam int TEX_W   = 10;
	localparam int DIST_W  = 7;
	localparam int IDX_W   = 3;

	// The screen and map sizes are powers of two, so the final scale is a shift.
	localparam int LOG_SW    = $clog2(PIX_COLS);
	localparam int LOG_HZ    = $clog2(HORIZON);
	localparam int LOG_MAP   = $clog2(MAP_W);
	localparam int DEN_SHIFT = FRAC_BITS + LOG_SW;
	localparam int Q_SHIFT   = DEN_SHIFT - LOG_MAP;

	localparam int NUM_W = 48;
	localparam int REM_W = 17;

	typedef logic signed [REG_W-1:0] reg_val_t;

	typedef enum logic [IDX_W-1:0] {
		REG_NEAR_LEFT_X  = 3'd0,
		REG_NEAR_LEFT_Y  = 3'd1,
		REG_FAR_LEFT_X   = 3'd2,
		REG_FAR_LEFT_Y   = 3'd3,
		REG_NEAR_RIGHT_X = 3'd4,
		REG_NEAR_RIGHT_Y = 3'd5,
		REG_FAR_RIGHT_X  = 3'd6,
		REG_FAR_RIGHT_Y  = 3'd7
	} reg_idx_t;

	localparam reg_val_t RST_NEAR_LEFT_X  = 26'sd8382676;
	localparam reg_val_t RST_NEAR_LEFT_Y  = 26'sd8382676;
	localparam reg_val_t RST_FAR_LEFT_X   = 26'sd8210656;
	localparam reg_val_t RST_FAR_LEFT_Y   = 26'sd8210656;
	localparam reg_val_t RST_NEAR_RIGHT_X = 26'sd8394540;
	localparam reg_val_t RST_NEAR_RIGHT_Y = 26'sd8382676;
	localparam reg_val_t RST_FAR_RIGHT_X  = 26'sd8566560;
	localparam reg_val_t RST_FAR_RIGHT_Y  = 26'sd8210656;

	// Flags that travel beside the arithmetic.
	typedef struct packed {
		logic sky;
		logic horizon;
	} pix_flags_t;

endpackage

### rtl/fpta_coord.sv
// ----------------------------------------------------------------------------
// fpta_coord
// Seven-stage pipeline for one map coordinate: builds the exact numerator,
// checks it against the unit range and divides by the row distance.
// ----------------------------------------------------------------------------
module fpta_coord (
	input  logic                         clk,
	input  logic                         en,
	input  fpta_pkg::reg_val_t           nl,
	input  fpta_pkg::reg_val_t           fl,
	input  fpta_pkg::reg_val_t           nr,
	input  fpta_pkg::reg_val_t           fr,
	input  logic [fpta_pkg::COL_W-1:0]   x,
	input  logic [fpta_pkg::DIST_W-1:0]  d,
	output logic [fpta_pkg::TEX_W-1:0]   q,
	output logic                         ok
);

	localparam int DW = fpta_pkg::DIST_W;
	localparam int RW = fpta_pkg::REM_W;
	localparam int TW = fpta_pkg::TEX_W;

	// Terms that depend on configuration only.
	logic signed [26:0] c_dx;
	logic signed [26:0] f_dx;
	logic signed [27:0] e_dx;

	assign c_dx = 27'(nr) - 27'(nl);
	assign f_dx = 27'(fl) - 27'(nl);
	assign e_dx = (28'(fr) - 28'(nr)) - 28'(f_dx);

	logic signed [37:0] p_s1;
	logic signed [37:0] e_s1;
	logic signed [26:0] nl_s1;
	logic signed [26:0] f_s1;
	logic [DW-1:0]      d_s1;

	logic signed [37:0] t1_s2;
	logic signed [45:0] t2_s2;
	logic [DW-1:0]      d_s2;

	logic signed [fpta_pkg::NUM_W-1:0] num_s3;
	logic [DW-1:0]                     d_s3;

	logic [RW-1:0]  rem_s4;
	logic           ok_s4;
	logic [DW-1:0]  d_s4;

	logic [RW-1:0]  rem_s5;
	logic [TW-1:0]  q_s5;
	logic           ok_s5;
	logic [DW-1:0]  d_s5;

	logic [RW-1:0]  rem_s6;
	logic [TW-1:0]  q_s6;
	logic           ok_s6;
	logic [DW-1:0]  d_s6;

	logic [TW-1:0]  q_s7;
	logic           ok_s7;

	logic signed [9:0] xs;
	assign xs = $signed({1'b0, x});

	// Stage 1: products with the column.
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1  <= 38'(c_dx) * 38'(xs);
			e_s1  <= 38'(e_dx) * 38'(xs);
			nl_s1 <= 27'(nl);
			f_s1  <= f_dx;
			d_s1  <= d;
		end
	end

	// Stage 2: the part scaled by the row distance and the part that is not.
	always_ff @(posedge clk) begin
		if (en) begin
			t1_s2 <= (38'(nl_s1) <<< fpta_pkg::LOG_SW) + p_s1;
			t2_s2 <= (46'(f_s1) <<< (fpta_pkg::LOG_HZ + fpta_pkg::LOG_SW))
				+ (46'(e_s1) <<< fpta_pkg::LOG_HZ);
			d_s2  <= d_s1;
		end
	end

	// Stage 3: full numerator over d * PIX_COLS * 2^FRAC_BITS.
	logic signed [DW:0] ds;
	assign ds = $signed({1'b0, d_s2});

	always_ff @(posedge clk) begin
		if (en) begin
			num_s3 <= fpta_pkg::NUM_W'(t1_s2) * fpta_pkg::NUM_W'(ds)
				+ fpta_pkg::NUM_W'(t2_s2);
			d_s3   <= d_s2;
		end
	end

	// Stage 4: range check; the scaled quotient only needs the high bits.
	logic [fpta_pkg::NUM_W-1:0] den_s3;
	assign den_s3 = fpta_pkg::NUM_W'(d_s3) << fpta_pkg::DEN_SHIFT;

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s4  <= !num_s3[fpta_pkg::NUM_W-1] && (unsigned'(num_s3) < den_s3);
			rem_s4 <= num_s3[fpta_pkg::Q_SHIFT +: RW];
			d_s4   <= d_s3;
		end
	end

	// Stages 5 to 7: restoring division, four, three and three quotient bits.
	logic [RW-1:0] r5, r6, r7;
	logic [TW-1:0] qq5, qq6, qq7;

	always_comb begin
		r5  = rem_s4;
		qq5 = '0;
		for (int j = TW - 1; j >= 6; j--) begin
			if (r5 >= (RW'(d_s4) << j)) begin
				r5     = r5 - (RW'(d_s4) << j);
				qq5[j] = 1'b1;
			end
		end
		r6  = rem_s5;
		qq6 = q_s5;
		for (int j = 5; j >= 3; j--) begin
			if (r6 >= (RW'(d_s5) << j)) begin
				r6     = r6 - (RW'(d_s5) << j);
				qq6[j] = 1'b1;
			end
		end
		r7  = rem_s6;
		qq7 = q_s6;
		for (int j = 2; j >= 0; j--) begin
			if (r7 >= (RW'(d_s6) << j)) begin
				r7     = r7 - (RW'(d_s6) << j);
				qq7[j] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s5 <= r5;
			q_s5   <= qq5;
			ok_s5  <= ok_s4;
			d_s5   <= d_s4;
			rem_s6 <= r6;
			q_s6   <= qq6;
			ok_s6  <= ok_s5;
			d_s6   <= d_s5;
			q_s7   <= qq7;
			ok_s7  <= ok_s6;
		end
	end

	// The last remainder is not needed.
	logic unused_r7;
	assign unused_r7 = ^r7;

	assign q  = q_s7 & {TW{~unused_r7 | unused_r7}};
	assign ok = ok_s7;

endmodule

### rtl/floor_projection_texel_address.sv
// ----------------------------------------------------------------------------
// floor_projection_texel_address
// Perspective floor mapping: screen pixel to floor map texel address.
// ----------------------------------------------------------------------------
// The block takes one pixel item per clock, unless the output holds it, and returns
// its texel address through seven stages: the column products, the edge sums, the
// row-distance multiply, the range check and three stages of a restoring
// divider. Both map coordinates run side by side in two copies of that
// pipeline. The whole pipeline holds when the output item is not taken.
// Frustum registers may be written only while no item is in flight.
module floor_projection_texel_address (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [fpta_pkg::IDX_W-1:0]        cfg_index,
	input  logic [fpta_pkg::REG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [fpta_pkg::COL_W-1:0]        pixel_col,
	input  logic [fpta_pkg::ROW_W-1:0]        pixel_row,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [fpta_pkg::TEX_W-1:0]        texel_col,
	output logic [fpta_pkg::TEX_W-1:0]        texel_row,
	output logic                              off_map,
	output logic                              sky_pixel
);

	localparam int STAGES = 7;

	fpta_pkg::reg_val_t regs_q [fpta_pkg::NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[fpta_pkg::REG_NEAR_LEFT_X]  <= fpta_pkg::RST_NEAR_LEFT_X;
			regs_q[fpta_pkg::REG_NEAR_LEFT_Y]  <= fpta_pkg::RST_NEAR_LEFT_Y;
			regs_q[fpta_pkg::REG_FAR_LEFT_X]   <= fpta_pkg::RST_FAR_LEFT_X;
			regs_q[fpta_pkg::REG_FAR_LEFT_Y]   <= fpta_pkg::RST_FAR_LEFT_Y;
			regs_q[fpta_pkg::REG_NEAR_RIGHT_X] <= fpta_pkg::RST_NEAR_RIGHT_X;
			regs_q[fpta_pkg::REG_NEAR_RIGHT_Y] <= fpta_pkg::RST_NEAR_RIGHT_Y;
			regs_q[fpta_pkg::REG_FAR_RIGHT_X]  <= fpta_pkg::RST_FAR_RIGHT_X;
			regs_q[fpta_pkg::REG_FAR_RIGHT_Y]  <= fpta_pkg::RST_FAR_RIGHT_Y;
		end else if (cfg_write) begin
			regs_q[cfg_index] <= $signed(cfg_data);
		end
	end

	logic adv;
	logic [STAGES-1:0] v_q;
	fpta_pkg::pix_flags_t flags_q [STAGES];
	fpta_pkg::pix_flags_t flags_in;

	assign adv      = !v_q[STAGES-1] || out_ready;
	assign in_ready = adv;

	assign flags_in.sky     = pixel_row < fpta_pkg::ROW_W'(fpta_pkg::HORIZON);
	assign flags_in.horizon = pixel_row == fpta_pkg::ROW_W'(fpta_pkg::HORIZON);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[STAGES-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flags_q[0] <= flags_in;
			for (int i = 1; i < STAGES; i++) begin
				flags_q[i] <= flags_q[i-1];
			end
		end
	end

	// Row distance below the horizon; meaningless for sky rows, masked later.
	logic [fpta_pkg::DIST_W-1:0] row_dist;
	logic [fpta_pkg::ROW_W-1:0]  dist_full;
	assign dist_full = pixel_row - fpta_pkg::ROW_W'(fpta_pkg::HORIZON);
	assign row_dist  = dist_full[fpta_pkg::DIST_W-1:0];

	logic [fpta_pkg::TEX_W-1:0] qx, qy;
	logic okx, oky;

	fpta_coord u_coord_x (
		.clk (clk),
		.en  (adv),
		.nl  (regs_q[fpta_pkg::REG_NEAR_LEFT_X]),
		.fl  (regs_q[fpta_pkg::REG_FAR_LEFT_X]),
		.nr  (regs_q[fpta_pkg::REG_NEAR_RIGHT_X]),
		.fr  (regs_q[fpta_pkg::REG_FAR_RIGHT_X]),
		.x   (pixel_col),
		.d   (row_dist),
		.q   (qx),
		.ok  (okx)
	);

	fpta_coord u_coord_y (
		.clk (clk),
		.en  (adv),
		.nl  (regs_q[fpta_pkg::REG_NEAR_LEFT_Y]),
		.fl  (regs_q[fpta_pkg::REG_FAR_LEFT_Y]),
		.nr  (regs_q[fpta_pkg::REG_NEAR_RIGHT_Y]),
		.fr  (regs_q[fpta_pkg::REG_FAR_RIGHT_Y]),
		.x   (pixel_col),
		.d   (row_dist),
		.q   (qy),
		.ok  (oky)
	);

	logic sky_o, hor_o, off_o;
	assign sky_o = flags_q[STAGES-1].sky;
	assign hor_o = flags_q[STAGES-1].horizon;
	assign off_o = !sky_o && (hor_o || !okx || !oky);

	assign out_valid = v_q[STAGES-1];
	assign sky_pixel = sky_o;
	assign off_map   = off_o;
	assign texel_col = (sky_o || off_o) ? '0 : qx;
	assign texel_row = (sky_o || off_o) ? '0 : qy;

endmodule

### sim/floor_projection_texel_address_tb.sv
// ----------------------------------------------------------------------------
// floor_projection_texel_address_tb
// Self-checking testbench for the perspective floor texel address block.
// A directed table covers sky, horizon, screen corners and frustum register
// extremes. Random pixels then run under several frustum settings. Every result
// is compared with a table entry or an in-bench projection model while the sender bursts and
// the receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module floor_projection_texel_address_tb;

	typedef struct packed {
		logic [fpta_pkg::TEX_W-1:0] tc;
		logic [fpta_pkg::TEX_W-1:0] tr;
		logic                       off;
		logic                       sky;
	} texel_t;

	typedef struct {
		int     col;
		int     row;
		bit     typed;
		texel_t exp;
	} pix_stim_t;

	localparam int WATCHDOG = 4000;
	localparam int DRAIN    = 12;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_write = 1'b0;
	logic [fpta_pkg::IDX_W-1:0] cfg_index = '0;
	logic [fpta_pkg::REG_W-1:0] cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [fpta_pkg::COL_W-1:0] pixel_col = '0;
	logic [fpta_pkg::ROW_W-1:0] pixel_row = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [fpta_pkg::TEX_W-1:0] texel_col;
	logic [fpta_pkg::TEX_W-1:0] texel_row;
	logic                       off_map;
	logic                       sky_pixel;

	longint frustum [fpta_pkg::NUM_REGS];
	texel_t texel_q [$];
	int     n_sent = 0, n_checked = 0, n_off = 0, n_sky = 0, n_errors = 0;
	int     n_settings = 0, idle_cycles = 0;
	int     rdy_mode = 0, rdy_ctr = 0;

	floor_projection_texel_address u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.pixel_col(pixel_col), .pixel_row(pixel_row),
		.out_valid(out_valid), .out_ready(out_ready),
		.texel_col(texel_col), .texel_row(texel_row),
		.off_map(off_map), .sky_pixel(sky_pixel)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// One map coordinate, formed as an exact fraction and floored once.
	function automatic bit map_coord(longint nl, longint fl, longint nr, longint fr,
			longint d, longint x, output logic [fpta_pkg::TEX_W-1:0] idx);
		longint k, den, num;
		k   = fpta_pkg::HORIZON;
		den = d * fpta_pkg::PIX_COLS * (64'sd1 <<< fpta_pkg::FRAC_BITS);
		num = nl * d * fpta_pkg::PIX_COLS + (fl - nl) * k * fpta_pkg::PIX_COLS
			+ (nr - nl) * d * x + ((fr - nr) - (fl - nl)) * k * x;
		idx = '0;
		if (num < 0 || num >= den)
			return 1'b0;
		idx = fpta_pkg::TEX_W'((num * fpta_pkg::MAP_W) / den);
		return 1'b1;
	endfunction

	function automatic texel_t project_pixel(int col, int row);
		texel_t t;
		bit     okx, oky;
		t = '0;
		if (row < fpta_pkg::HORIZON) begin
			t.sky = 1'b1;
		end else if (row == fpta_pkg::HORIZON) begin
			t.off = 1'b1;
		end else begin
			okx = map_coord(frustum[fpta_pkg::REG_NEAR_LEFT_X],
				frustum[fpta_pkg::REG_FAR_LEFT_X], frustum[fpta_pkg::REG_NEAR_RIGHT_X],
				frustum[fpta_pkg::REG_FAR_RIGHT_X], row - fpta_pkg::HORIZON, col, t.tc);
			oky = map_coord(frustum[fpta_pkg::REG_NEAR_LEFT_Y],
				frustum[fpta_pkg::REG_FAR_LEFT_Y], frustum[fpta_pkg::REG_NEAR_RIGHT_Y],
				frustum[fpta_pkg::REG_FAR_RIGHT_Y], row - fpta_pkg::HORIZON, col, t.tr);
			if (!okx || !oky) begin
				t = '0;
				t.off = 1'b1;
			end
		end
		return t;
	endfunction

	task automatic send_pixel(int col, int row, bit typed, texel_t exp);
		texel_t want;
		@(negedge clk);
		in_valid  <= 1'b1;
		pixel_col <= fpta_pkg::COL_W'(col);
		pixel_row <= fpta_pkg::ROW_W'(row);
		do @(posedge clk); while (!in_ready);
		want = typed ? exp : project_pixel(col, row);
		texel_q = {texel_q, want};
		n_sent++;
	endtask

	task automatic pause_sender(int cycles);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic wait_drained();
		pause_sender(0);
		while (texel_q.size() != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic set_frustum(fpta_pkg::reg_idx_t idx, longint val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= fpta_pkg::REG_W'(val);
		@(negedge clk);
		cfg_write <= 1'b0;
		frustum[idx] = val;
	endtask

	task automatic load_frustum(int kind);
		longint v;
		wait_drained();
		for (int i = 0; i < fpta_pkg::NUM_REGS; i++) begin
			case (kind)
				0: v = (64'sd1 <<< (fpta_pkg::REG_W - 1)) - 1;
				1: v = -(64'sd1 <<< (fpta_pkg::REG_W - 1));
				2: v = longint'($urandom_range(0, (1 << fpta_pkg::FRAC_BITS) - 1));
				default: v = longint'($signed(fpta_pkg::REG_W'($urandom)));
			endcase
			set_frustum(fpta_pkg::reg_idx_t'(i), v);
		end
		n_settings++;
	endtask

	task automatic random_pixels(int count);
		int left, burst, col, row;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 24);
			for (int b = 0; b < burst && left > 0; b++) begin
				col = $urandom_range(0, 511);
				// Mostly floor rows, where the projection math is exercised.
				row = ($urandom_range(0, 9) < 8)
					? $urandom_range(fpta_pkg::HORIZON + 1, 255)
					: $urandom_range(0, 255);
				send_pixel(col, row, 1'b0, '0);
				left--;
			end
			if ($urandom_range(0, 3) != 0)
				pause_sender($urandom_range(0, 8));
		end
	endtask

	// Receiver: always ready, random stalls, or a periodic stall.
	always @(negedge clk) begin
		rdy_ctr <= rdy_ctr + 1;
		if (rdy_ctr % 64 == 0)
			rdy_mode <= $urandom_range(0, 2);
		case (rdy_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 9) < 7);
			default: out_ready <= (rdy_ctr % 3 != 0);
		endcase
	end

	always @(posedge clk) begin
		texel_t exp;
		if (in_valid && in_ready || out_valid && out_ready || cfg_write)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("%0t: watchdog expired, %0d results outstanding", $time,
				texel_q.size());
			$display("FAIL floor_projection_texel_address");
			$finish;
		end
		if (arst_n && out_valid && out_ready) begin
			if (texel_q.size() == 0) begin
				$display("%0t: unexpected item tc=%0d tr=%0d off=%0b sky=%0b", $time,
					texel_col, texel_row, off_map, sky_pixel);
				n_errors++;
			end else begin
				exp = texel_q.pop_front();
				n_checked++;
				n_off += exp.off;
				n_sky += exp.sky;
				if (texel_col !== exp.tc) begin
					$display("%0t: texel_col expected %0d actual %0d", $time, exp.tc, texel_col);
					n_errors++;
				end
				if (texel_row !== exp.tr) begin
					$display("%0t: texel_row expected %0d actual %0d", $time, exp.tr, texel_row);
					n_errors++;
				end
				if (off_map !== exp.off) begin
					$display("%0t: off_map expected %0b actual %0b", $time, exp.off, off_map);
					n_errors++;
				end
				if (sky_pixel !== exp.sky) begin
					$display("%0t: sky_pixel expected %0b actual %0b", $time, exp.sky, sky_pixel);
					n_errors++;
				end
			end
		end
	end

	initial begin
		pix_stim_t dir_tab [14];
		texel_t    sky_t, hor_t, off_t;
		sky_t = '{tc: '0, tr: '0, off: 1'b0, sky: 1'b1};
		hor_t = '{tc: '0, tr: '0, off: 1'b1, sky: 1'b0};
		off_t = hor_t;
		dir_tab = '{
			'{0, 0, 1, sky_t}, '{511, 127, 1, sky_t}, '{256, 64, 1, sky_t},
			'{0, 128, 1, hor_t}, '{511, 128, 1, hor_t},
			'{0, 129, 0, '0}, '{511, 129, 0, '0}, '{0, 255, 0, '0}, '{511, 255, 0, '0},
			'{256, 192, 0, '0}, '{255, 170, 0, '0}, '{1, 200, 0, '0},
			'{510, 130, 0, '0}, '{170, 213, 0, '0}
		};
		frustum = '{fpta_pkg::RST_NEAR_LEFT_X, fpta_pkg::RST_NEAR_LEFT_Y,
			fpta_pkg::RST_FAR_LEFT_X, fpta_pkg::RST_FAR_LEFT_Y,
			fpta_pkg::RST_NEAR_RIGHT_X, fpta_pkg::RST_NEAR_RIGHT_Y,
			fpta_pkg::RST_FAR_RIGHT_X, fpta_pkg::RST_FAR_RIGHT_Y};
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[i])
			send_pixel(dir_tab[i].col, dir_tab[i].row, dir_tab[i].typed, dir_tab[i].exp);

		// At the register extremes every corner lies far off the map.
		load_frustum(0);
		for (int i = 5; i < 9; i++)
			send_pixel(dir_tab[i].col, dir_tab[i].row, 1'b1, off_t);
		load_frustum(1);
		for (int i = 5; i < 9; i++)
			send_pixel(dir_tab[i].col, dir_tab[i].row, 1'b1, off_t);

		for (int s = 0; s < 7; s++) begin
			load_frustum((s == 3 || s == 6) ? 3 : 2);
			random_pixels(40);
			// Hold the sender once until the pipeline is empty.
			if (s == 2)
				wait_drained();
			random_pixels(15);
		end
		wait_drained();
		random_pixels(15);

		pause_sender(0);
		while (texel_q.size() != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);

		$display("Checked %0d of %0d pixels over %0d frustum settings.", n_checked, n_sent,
			n_settings + 1);
		$display("Results: %0d sky, %0d off map or horizon, %0d mismatches.", n_sky, n_off,
			n_errors);
		if (n_errors == 0 && texel_q.size() == 0)
			$display("PASS floor_projection_texel_address");
		else
			$display("FAIL floor_projection_texel_address");
		$finish;
	end

endmodule

### files.f
rtl/fpta_pkg.sv
rtl/fpta_coord.sv
rtl/floor_projection_texel_address.sv
sim/floor_projection_texel_address_tb.sv
